>>> design/sfd_pkg.sv
// Shared types, constants and the CRC-8 step for the sensor frame deframer.
package sfd_pkg;

	// Default total buffer size; the payload part is this minus the header bytes.
	localparam int BUFFER_BYTES_DEF = 64;
	localparam int HEADER_BYTES = 8;
	localparam logic [7:0] CRC_POLY = 8'h31;

	// Depth of the command queue between the parser and the output side.
	localparam int CMDQ_DEPTH = 2;

	typedef enum logic [1:0] {
		ST_GOOD    = 2'd0,
		ST_CRC_ERR = 2'd1,
		ST_LEN_ERR = 2'd2
	} frame_status_t;

	// One finished frame as handed from the parser to the output side.
	typedef struct packed {
		frame_status_t status;
		logic [7:0]    sensor_kind;
		logic [7:0]    sensor_number;
		logic [15:0]   sequence_number;
		logic [7:0]    payload_kind;
		logic [7:0]    length;
		logic          bank;
	} frame_cmd_t;

	// Tells the parser that a payload bank has been read out and may be reused.
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_free_t;

	// One byte of CRC-8, polynomial 0x31, MSB first.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

>>> design/sfd_front.sv
// Parser: hunts for the start byte, collects the header, checks the CRC and queues frames.
module sfd_front #(
	parameter int BUFFER_BYTES = sfd_pkg::BUFFER_BYTES_DEF
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   start_byte_we,
	input  logic [7:0]                                             start_byte,
	input  logic                                                   in_valid,
	output logic                                                   in_stall,
	input  logic [7:0]                                             rx_byte,
	output logic                                                   cmd_push,
	output sfd_pkg::frame_cmd_t                                    cmd_data,
	input  logic                                                   cmd_full,
	input  sfd_pkg::bank_free_t                                    bank_free,
	output logic                                                   mem_we,
	output logic                                                   mem_bank,
	output logic [$clog2(BUFFER_BYTES - sfd_pkg::HEADER_BYTES)-1:0] mem_addr,
	output logic [7:0]                                             mem_data
);

	localparam int MAX_PAYLOAD = BUFFER_BYTES - sfd_pkg::HEADER_BYTES;
	localparam int IW = $clog2(MAX_PAYLOAD);
	localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);
	localparam logic [7:0] PosLen = 8'd1;
	localparam logic [7:0] PosKind = 8'd2;
	localparam logic [7:0] PosNumber = 8'd3;
	localparam logic [7:0] PosSeqHi = 8'd4;
	localparam logic [7:0] PosSeqLo = 8'd5;
	localparam logic [7:0] PosPayKind = 8'd6;
	localparam logic [7:0] PosBody = 8'd7;

	logic [7:0]  start_q;
	logic [7:0]  pos_q;
	logic [7:0]  len_q;
	logic [7:0]  crc_q;
	logic [7:0]  kind_q;
	logic [7:0]  number_q;
	logic [15:0] seq_q;
	logic [7:0]  pkind_q;
	logic        wr_bank_q;
	logic [1:0]  busy_q;

	logic        accept;
	logic        in_body;
	logic        at_crc;
	logic        crc_ok;
	logic        len_bad;
	logic        good_payload;
	logic [7:0]  crc_next;
	logic [7:0]  body_idx;
	logic [1:0]  busy_n;

	always_comb begin
		// A byte waits while the bank it would fill holds an undelivered frame, or on cmd_full.
		in_stall = busy_q[wr_bank_q] | cmd_full;
		accept = in_valid & ~in_stall;
		in_body = {1'b0, pos_q} < ({1'b0, len_q} + 9'(PosBody));
		at_crc = (pos_q >= PosKind) & ~in_body;
		crc_ok = rx_byte == crc_q;
		len_bad = (pos_q == PosLen) & (rx_byte > MaxLen);
		good_payload = at_crc & crc_ok & (len_q != 8'd0);
		crc_next = sfd_pkg::crc8_update(crc_q, rx_byte);
		body_idx = pos_q - PosBody;

		mem_we = accept & (pos_q >= PosBody) & in_body;
		mem_bank = wr_bank_q;
		mem_addr = body_idx[IW-1:0];
		mem_data = rx_byte;

		cmd_push = accept & (len_bad | at_crc);
		cmd_data.status = crc_ok ? sfd_pkg::ST_GOOD : sfd_pkg::ST_CRC_ERR;
		cmd_data.sensor_kind = kind_q;
		cmd_data.sensor_number = number_q;
		cmd_data.sequence_number = seq_q;
		cmd_data.payload_kind = pkind_q;
		cmd_data.length = len_q;
		cmd_data.bank = wr_bank_q;
		if (len_bad) begin
			cmd_data.status = sfd_pkg::ST_LEN_ERR;
			cmd_data.sensor_kind = 8'd0;
			cmd_data.sensor_number = 8'd0;
			cmd_data.sequence_number = 16'd0;
			cmd_data.payload_kind = 8'd0;
			cmd_data.length = 8'd0;
		end

		busy_n = busy_q;
		if (bank_free.valid) begin
			busy_n[bank_free.bank] = 1'b0;
		end
		if (accept & good_payload) begin
			busy_n[wr_bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 8'd0;
			pos_q <= 8'd0;
			len_q <= 8'd0;
			crc_q <= 8'd0;
			wr_bank_q <= 1'b0;
			busy_q <= 2'b00;
		end else begin
			busy_q <= busy_n;
			if (start_byte_we) begin
				start_q <= start_byte;
			end
			if (accept) begin
				if (pos_q == 8'd0) begin
					if (rx_byte == start_q) begin
						pos_q <= PosLen;
						crc_q <= 8'd0;
					end
				end else if (pos_q == PosLen) begin
					if (len_bad) begin
						pos_q <= 8'd0;
					end else begin
						len_q <= rx_byte;
						crc_q <= sfd_pkg::crc8_update(8'd0, rx_byte);
						pos_q <= PosKind;
					end
				end else if (in_body) begin
					crc_q <= crc_next;
					pos_q <= pos_q + 8'd1;
				end else begin
					pos_q <= 8'd0;
					if (good_payload) begin
						wr_bank_q <= ~wr_bank_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (pos_q)
				PosKind:    kind_q <= rx_byte;
				PosNumber:  number_q <= rx_byte;
				PosSeqHi:   seq_q[15:8] <= rx_byte;
				PosSeqLo:   seq_q[7:0] <= rx_byte;
				PosPayKind: pkind_q <= rx_byte;
				default:    ;
			endcase
		end
	end

endmodule

>>> design/sfd_cmdq.sv
// Short queue of finished frame commands between the parser and the output side.
module sfd_cmdq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sfd_pkg::frame_cmd_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output sfd_pkg::frame_cmd_t head
);

	localparam int PW = $clog2(sfd_pkg::CMDQ_DEPTH);
	localparam logic [PW:0] Depth = (PW + 1)'(sfd_pkg::CMDQ_DEPTH);

	sfd_pkg::frame_cmd_t entry_q [sfd_pkg::CMDQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full = count_q == Depth;
	assign not_empty = count_q != '0;
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push & ~pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop & ~push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> design/sfd_back.sv
// Output side: holds the two payload banks and plays out each queued frame as result words.
module sfd_back #(
	parameter int BUFFER_BYTES = sfd_pkg::BUFFER_BYTES_DEF
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   mem_we,
	input  logic                                                   mem_bank,
	input  logic [$clog2(BUFFER_BYTES - sfd_pkg::HEADER_BYTES)-1:0] mem_addr,
	input  logic [7:0]                                             mem_data,
	input  logic                                                   cmd_valid,
	input  sfd_pkg::frame_cmd_t                                    cmd_head,
	output logic                                                   cmd_pop,
	output sfd_pkg::bank_free_t                                    bank_free,
	output logic                                                   out_valid,
	input  logic                                                   out_stall,
	output logic [1:0]                                             frame_status,
	output logic [7:0]                                             sensor_kind,
	output logic [7:0]                                             sensor_number,
	output logic [15:0]                                            sequence_number,
	output logic [7:0]                                             payload_kind,
	output logic [7:0]                                             payload_byte,
	output logic                                                   byte_valid,
	output logic                                                   last_of_frame
);

	localparam int MAX_PAYLOAD = BUFFER_BYTES - sfd_pkg::HEADER_BYTES;
	localparam int IW = $clog2(MAX_PAYLOAD);

	logic [7:0] mem [2][MAX_PAYLOAD];

	logic [IW-1:0]       k_q;
	logic [7:0]          rd_q;
	logic                valid_s1;
	sfd_pkg::frame_cmd_t hdr_s1;
	logic                bval_s1;
	logic                last_s1;

	logic                valid_s2;
	logic [1:0]          status_s2;
	logic [7:0]          kind_s2;
	logic [7:0]          number_s2;
	logic [15:0]         seq_s2;
	logic [7:0]          pkind_s2;
	logic [7:0]          data_s2;
	logic                bval_s2;
	logic                last_s2;

	logic advance;
	logic s1_free;
	logic issue;
	logic has_payload;
	logic word_last;

	always_comb begin
		advance = ~valid_s2 | ~out_stall;
		s1_free = ~valid_s1 | advance;
		issue = cmd_valid & s1_free;
		has_payload = (cmd_head.status == sfd_pkg::ST_GOOD) & (cmd_head.length != 8'd0);
		// Error and empty frames are a single word; others end at the last payload byte.
		word_last = has_payload ? ((8'(k_q) + 8'd1) == cmd_head.length) : 1'b1;
		cmd_pop = issue & word_last;
		bank_free.valid = cmd_pop & has_payload;
		bank_free.bank = cmd_head.bank;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_bank][mem_addr] <= mem_data;
		end
		if (issue) begin
			rd_q <= mem[cmd_head.bank][k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (issue) begin
				k_q <= cmd_pop ? '0 : k_q + 1'b1;
			end
			if (s1_free) begin
				valid_s1 <= issue;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			hdr_s1 <= cmd_head;
			bval_s1 <= has_payload;
			last_s1 <= word_last;
		end
		if (advance & valid_s1) begin
			status_s2 <= hdr_s1.status;
			kind_s2 <= hdr_s1.sensor_kind;
			number_s2 <= hdr_s1.sensor_number;
			seq_s2 <= hdr_s1.sequence_number;
			pkind_s2 <= hdr_s1.payload_kind;
			data_s2 <= bval_s1 ? rd_q : 8'd0;
			bval_s2 <= bval_s1;
			last_s2 <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign frame_status = status_s2;
	assign sensor_kind = kind_s2;
	assign sensor_number = number_s2;
	assign sequence_number = seq_s2;
	assign payload_kind = pkind_s2;
	assign payload_byte = data_s2;
	assign byte_valid = bval_s2;
	assign last_of_frame = last_s2;

endmodule

>>> design/sensor_frame_deframer_crc8.sv
// From its CRC byte to its first result word, a frame passes the frame queue, s1 and s2.
// Throughput: one received byte per cycle, one result word per cycle, each unless stalled.
// Input stalls only while both payload banks hold frames not yet played out,
// or while the two-entry frame queue is full.
// Reset clears all control state and start_byte to zero; the block starts hunting.
module sensor_frame_deframer_crc8 #(
	parameter int BUFFER_BYTES = sfd_pkg::BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start_byte_we,
	input  logic [7:0]  start_byte,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  frame_status,
	output logic [7:0]  sensor_kind,
	output logic [7:0]  sensor_number,
	output logic [15:0] sequence_number,
	output logic [7:0]  payload_kind,
	output logic [7:0]  payload_byte,
	output logic        byte_valid,
	output logic        last_of_frame
);

	localparam int IW = $clog2(BUFFER_BYTES - sfd_pkg::HEADER_BYTES);

	logic                cmd_push;
	sfd_pkg::frame_cmd_t cmd_data;
	logic                cmd_full;
	logic                cmd_pop;
	logic                cmd_valid;
	sfd_pkg::frame_cmd_t cmd_head;
	sfd_pkg::bank_free_t bank_free;
	logic                mem_we;
	logic                mem_bank;
	logic [IW-1:0]       mem_addr;
	logic [7:0]          mem_data;

	sfd_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start_byte_we (start_byte_we),
		.start_byte    (start_byte),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.cmd_push      (cmd_push),
		.cmd_data      (cmd_data),
		.cmd_full      (cmd_full),
		.bank_free     (bank_free),
		.mem_we        (mem_we),
		.mem_bank      (mem_bank),
		.mem_addr      (mem_addr),
		.mem_data      (mem_data)
	);

	sfd_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_data),
		.full      (cmd_full),
		.pop       (cmd_pop),
		.not_empty (cmd_valid),
		.head      (cmd_head)
	);

	sfd_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.mem_we          (mem_we),
		.mem_bank        (mem_bank),
		.mem_addr        (mem_addr),
		.mem_data        (mem_data),
		.cmd_valid       (cmd_valid),
		.cmd_head        (cmd_head),
		.cmd_pop         (cmd_pop),
		.bank_free       (bank_free),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.frame_status    (frame_status),
		.sensor_kind     (sensor_kind),
		.sensor_number   (sensor_number),
		.sequence_number (sequence_number),
		.payload_kind    (payload_kind),
		.payload_byte    (payload_byte),
		.byte_valid      (byte_valid),
		.last_of_frame   (last_of_frame)
	);

endmodule

>>> design/sfd_check.sv
// Port-level checks on the deframer's result words, bound to the top level.
module sfd_check (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  frame_status,
	input logic [7:0]  sensor_kind,
	input logic [7:0]  sensor_number,
	input logic [15:0] sequence_number,
	input logic [7:0]  payload_byte,
	input logic        byte_valid,
	input logic        last_of_frame
);

	// A stalled result word stays put until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte)
			&& $stable(frame_status) && $stable(last_of_frame)
			&& $stable(sequence_number) && $stable(sensor_kind))
		else $error("stalled result word changed");

	// Only a good frame carries payload bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> frame_status == sfd_pkg::ST_GOOD)
		else $error("payload byte in an error word");

	// An error word is always the single, closing word of its frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status != sfd_pkg::ST_GOOD |-> last_of_frame && !byte_valid)
		else $error("error word not a lone closing word");

	// A word without data reads zero and closes its frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> payload_byte == 8'd0 && last_of_frame)
		else $error("empty word carries data or does not close the frame");

	// An oversize length reports no header.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status == sfd_pkg::ST_LEN_ERR
			|-> sensor_kind == 8'd0 && sensor_number == 8'd0 && sequence_number == 16'd0)
		else $error("length error word carries header fields");

endmodule

bind sensor_frame_deframer_crc8 sfd_check u_sfd_check (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.frame_status    (frame_status),
	.sensor_kind     (sensor_kind),
	.sensor_number   (sensor_number),
	.sequence_number (sequence_number),
	.payload_byte    (payload_byte),
	.byte_valid      (byte_valid),
	.last_of_frame   (last_of_frame)
);
